// ----- sv/b64u_pkg.sv -----
// Shared types and the symbol alphabet for the unpadded URL-safe base64 encoder.
// Used by the front end, the queue and the symbol back end.
`default_nettype none
package b64u_pkg;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned GROUP_W = 6;
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W  = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W  = $clog2(QUEUE_DEPTH + 1);

  // One queued work item: one or two 6-bit groups and the end-of-message mark.
  typedef struct packed {
    logic [GROUP_W-1:0] group0;
    logic [GROUP_W-1:0] group1;
    logic               two;
    logic               eom;
  } b64u_entry_t;

  // Maps a 6-bit group to its ASCII code: A-Z, a-z, 0-9, '-', '_'.
  function automatic logic [BYTE_W-1:0] b64u_symbol(input logic [GROUP_W-1:0] g);
    logic [BYTE_W-1:0] gx;
    gx = {2'b00, g};
    if (g < 6'd26) begin
      b64u_symbol = gx + 8'h41;
    end else if (g < 6'd52) begin
      b64u_symbol = gx + 8'h47;
    end else if (g < 6'd62) begin
      b64u_symbol = gx - 8'h04;
    end else if (g == 6'd62) begin
      b64u_symbol = 8'h2D;
    end else begin
      b64u_symbol = 8'h5F;
    end
  endfunction

endpackage
`default_nettype wire

// ----- sv/b64u_front.sv -----
// Front end: takes one byte per request, merges it with leftover bits and
// splits the result into one or two 6-bit groups. Depends on b64u_pkg.
`default_nettype none
module b64u_front (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      accept,
  input  wire logic [b64u_pkg::BYTE_W-1:0] data_byte,
  input  wire logic                      end_of_message,
  output b64u_pkg::b64u_entry_t          entry
);
  import b64u_pkg::*;

  // Number of leftover bits carried from the previous byte.
  typedef enum logic [1:0] {PH_0, PH_2, PH_4} phase_t;

  phase_t     phase, phase_next;
  logic [3:0] pend, pend_next;

  always_comb begin
    entry.eom  = end_of_message;
    entry.two  = end_of_message;
    phase_next = end_of_message ? PH_0 : PH_2;
    pend_next  = {2'b00, data_byte[1:0]};
    unique case (phase)
      PH_2: begin
        entry.group0 = {pend[1:0], data_byte[7:4]};
        entry.group1 = {data_byte[3:0], 2'b00};
        phase_next   = end_of_message ? PH_0 : PH_4;
        pend_next    = data_byte[3:0];
      end
      PH_4: begin
        entry.group0 = {pend[3:0], data_byte[7:6]};
        entry.group1 = data_byte[5:0];
        entry.two    = 1'b1;
        phase_next   = PH_0;
        pend_next    = 4'd0;
      end
      default: begin
        entry.group0 = data_byte[7:2];
        entry.group1 = {data_byte[1:0], 4'b0000};
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_0;
    end else if (accept) begin
      phase <= phase_next;
    end
    if (accept) begin
      pend <= pend_next;
    end
  end

endmodule
`default_nettype wire

// ----- sv/b64u_queue.sv -----
// Short queue of work items between the front end and the back end.
// Depends on b64u_pkg for the item type and depth.
`default_nettype none
module b64u_queue (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire b64u_pkg::b64u_entry_t push_entry,
  input  wire logic             pop,
  output b64u_pkg::b64u_entry_t head,
  output logic                  full,
  output logic                  not_empty
);
  import b64u_pkg::*;

  b64u_entry_t         mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr, rd_ptr;
  logic [QCNT_W-1:0]   count;

  assign full      = (count == QCNT_W'(QUEUE_DEPTH));
  assign not_empty = (count != '0);
  assign head      = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
    if (push) begin
      mem[wr_ptr] <= push_entry;
    end
  end

endmodule
`default_nettype wire

// ----- sv/b64u_back.sv -----
// Back end: turns each queued item into one or two ASCII symbols, one per
// cycle unless the output stalls, into the output register. Depends on b64u_pkg.
`default_nettype none
module b64u_back (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire b64u_pkg::b64u_entry_t       head,
  input  wire logic                        not_empty,
  output logic                             pop,
  output logic                             m_tvalid,
  input  wire logic                        m_tready,
  output logic [b64u_pkg::BYTE_W-1:0]      m_tdata,
  output logic                             m_tlast
);
  import b64u_pkg::*;

  logic               sel;
  logic               load;
  logic               last_of_item;
  logic [GROUP_W-1:0] group;

  assign load         = not_empty && (!m_tvalid || m_tready);
  assign last_of_item = !head.two || sel;
  assign pop          = load && last_of_item;
  assign group        = sel ? head.group1 : head.group0;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      sel      <= 1'b0;
    end else begin
      if (load) begin
        m_tvalid <= 1'b1;
        sel      <= !last_of_item;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
    if (load) begin
      m_tdata <= b64u_symbol(group);
      m_tlast <= head.eom && last_of_item;
    end
  end

endmodule
`default_nettype wire

// ----- sv/base64url_encoder.sv -----
// Top level of the unpadded URL-safe base64 encoder: front end, work queue
// and symbol back end. Depends on b64u_pkg, b64u_front, b64u_queue, b64u_back.
//
//   Channel   Dir  tdata bits             tlast
//   s_*       in   [7:0] data_byte        end_of_message
//   m_*       out  [7:0] symbol           final_symbol
//
// Each byte yields one or two symbols; the back end emits one symbol per
// cycle while the output is not stalled, so bytes are sustained at one per
// cycle only while each byte yields one symbol.
// A two-entry queue lets the input keep accepting while the output stalls, until it is full.
// Reset (synchronous) clears the leftover-bit phase, the queue and the
// output valid; a new message starts with no leftover bits.
`default_nettype none
module base64url_encoder (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   s_tvalid,
  output logic                        s_tready,
  input  wire logic [7:0]             s_tdata,   // [7:0] data_byte
  input  wire logic                   s_tlast,
  output logic                        m_tvalid,
  input  wire logic                   m_tready,
  output logic [7:0]                  m_tdata,   // [7:0] symbol
  output logic                        m_tlast
);
  import b64u_pkg::*;

  b64u_entry_t entry, head;
  logic        accept, full, not_empty, pop;

  assign s_tready = !full;
  assign accept   = s_tvalid && s_tready;

  b64u_front u_front (
    .clk            (clk),
    .rst            (rst),
    .accept         (accept),
    .data_byte      (s_tdata),
    .end_of_message (s_tlast),
    .entry          (entry)
  );

  b64u_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (accept),
    .push_entry (entry),
    .pop        (pop),
    .head       (head),
    .full       (full),
    .not_empty  (not_empty)
  );

  b64u_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .not_empty (not_empty),
    .pop       (pop),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast)
  );

endmodule
`default_nettype wire

// ----- sv/b64u_checker.sv -----
// Port-level checks for the encoder top level, attached with a bind.
// Depends only on the ports of base64url_encoder.
`default_nettype none
module b64u_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       s_tvalid,
  input wire logic       s_tready,
  input wire logic       m_tvalid,
  input wire logic       m_tready,
  input wire logic [7:0] m_tdata,
  input wire logic       m_tlast
);

  // A stalled symbol must hold its value and flag.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("output changed while stalled");

  // Every symbol shown is in the URL-safe alphabet.
  a_alpha: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ((m_tdata >= 8'h41 && m_tdata <= 8'h5A) ||
                  (m_tdata >= 8'h61 && m_tdata <= 8'h7A) ||
                  (m_tdata >= 8'h30 && m_tdata <= 8'h39) ||
                  m_tdata == 8'h2D || m_tdata == 8'h5F))
    else $error("symbol outside the alphabet");

  // Reset empties the output register.
  a_reset: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid after reset");

  // An input request accepted with an empty output shows a symbol once it has
  // passed through the queue and the output register.
  a_progress: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && !m_tvalid && !$past(m_tvalid) && !$past(rst)
      |=> ##1 m_tvalid)
    else $error("no symbol after an accepted byte");

endmodule

bind base64url_encoder b64u_checker u_chk (.*);
`default_nettype wire

// ----- tb/sv/base64url_encoder_test.sv -----
// Self-checking testbench for base64url_encoder: directed and random messages on the
// input stream, with a scoreboard class that predicts every symbol of the output stream.
// Depends only on the RTL (base64url_encoder and the modules under it).
module base64url_encoder_test;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0] symbol;
    logic       last_sym;
  } encoded_symbol_t;

  // Predicts the symbols for each accepted request and checks the output stream.
  class encoder_scoreboard;
    encoded_symbol_t expected_symbols[$];
    logic [3:0] carry_bits;
    int unsigned carry_count;
    int unsigned errors;
    string alphabet;

    function new();
      alphabet = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789-_";
      carry_bits = 4'h0;
      carry_count = 0;
      errors = 0;
    endfunction

    function void push_group(logic [5:0] group, logic last_flag);
      encoded_symbol_t s;
      s.symbol = alphabet[group];
      s.last_sym = last_flag;
      expected_symbols.push_back(s);
    endfunction

    function void note_byte(logic [7:0] data_byte, logic eom);
      logic [11:0] acc;
      logic [11:0] field;
      int unsigned cnt;
      cnt = carry_count;
      acc = (({8'h00, carry_bits} & ((12'd1 << cnt) - 12'd1)) << 8) | {4'h0, data_byte};
      cnt = cnt + 8;
      while (cnt >= 6) begin
        cnt = cnt - 6;
        field = acc >> cnt;
        push_group(field[5:0], eom && cnt == 0);
        acc = acc & ((12'd1 << cnt) - 12'd1);
      end
      if (eom) begin
        // Leftover bits are padded with zeros on the right into one last symbol.
        if (cnt > 0) begin
          field = acc << (6 - cnt);
          push_group(field[5:0], 1'b1);
        end
        carry_bits = 4'h0;
        carry_count = 0;
      end else begin
        carry_bits = acc[3:0];
        carry_count = cnt;
      end
    endfunction

    function void check_symbol(logic [7:0] symbol, logic last_flag);
      encoded_symbol_t want;
      if (expected_symbols.size() == 0) begin
        $display("%0t: unexpected symbol: expected none, actual %h last %b",
                 $time, symbol, last_flag);
        errors++;
        return;
      end
      want = expected_symbols.pop_front();
      if (want.symbol !== symbol || want.last_sym !== last_flag) begin
        $display("%0t: symbol mismatch: expected %h last %b, actual %h last %b",
                 $time, want.symbol, want.last_sym, symbol, last_flag);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return expected_symbols.size();
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst;
  logic       s_tvalid;
  logic       s_tready;
  logic [7:0] s_tdata;   // [7:0] data_byte
  logic       s_tlast;
  logic       m_tvalid;
  logic       m_tready;
  logic [7:0] m_tdata;   // [7:0] symbol
  logic       m_tlast;

  encoder_scoreboard book = new();
  int unsigned bytes_sent = 0;
  logic        quiet = 1'b0;
  int unsigned holdoff_seq = 0;

  base64url_encoder uut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tlast(s_tlast),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tlast(m_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("FAIL base64url_encoder");
    $finish;
  end

  // Output side: random stalls, plus a long hold-off each time the sender asks for one.
  initial begin
    int unsigned holdoff_seen;
    int unsigned holdoff_left;
    holdoff_seen = 0;
    holdoff_left = 0;
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (holdoff_seq != holdoff_seen) begin
        holdoff_seen = holdoff_seq;
        holdoff_left = 120;
      end
      if (holdoff_left > 0) begin
        m_tready <= 1'b0;
        holdoff_left--;
      end else begin
        m_tready <= quiet || $urandom_range(0, 99) >= 10;
      end
      @(posedge clk);
      if (m_tvalid === 1'b1 && m_tready === 1'b1) begin
        book.check_symbol(m_tdata, m_tlast);
      end
    end
  end

  // Presents one request and returns at the rising edge where it is accepted.
  task automatic send_byte(input logic [7:0] data_byte, input logic eom);
    @(negedge clk);
    while (!quiet && $urandom_range(0, 99) < 10) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= data_byte;
    s_tlast <= eom;
    do @(posedge clk); while (s_tready !== 1'b1);
    book.note_byte(data_byte, eom);
    bytes_sent++;
  endtask

  task automatic release_input();
    @(negedge clk);
    s_tvalid <= 1'b0;
  endtask

  task automatic send_random_message(input int unsigned len);
    logic [7:0] b;
    for (int unsigned i = 0; i < len; i++) begin
      case ($urandom_range(0, 15))
        0: b = 8'h00;
        1: b = 8'hFF;
        default: b = 8'($urandom_range(0, 255));
      endcase
      send_byte(b, i == len - 1);
    end
  endtask

  task automatic wait_drained();
    while (book.pending() != 0) @(posedge clk);
  endtask

  initial begin
    int unsigned len;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = 8'h00;
    s_tlast = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Single bytes, so the final symbol carries padded leftover bits.
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b1);
    // Two bytes leave four bits for the padded symbol.
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b1);
    // Three bytes fit exactly, so the fourth group carries the final mark.
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b1);
    // Groups of all '-' symbols, then a message of mixed groups.
    send_byte(8'hFB, 1'b0);
    send_byte(8'hEF, 1'b0);
    send_byte(8'hBE, 1'b1);
    send_byte(8'h01, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h7F, 1'b0);
    send_byte(8'h55, 1'b1);

    while (bytes_sent < 280) begin
      if ($urandom_range(0, 9) == 0) begin
        len = $urandom_range(7, 20);
      end else begin
        len = $urandom_range(1, 6);
      end
      send_random_message(len);
      if (bytes_sent >= 80 && holdoff_seq == 0) begin
        // Stall the output for a long stretch while a long message keeps coming.
        holdoff_seq++;
        send_random_message(16);
      end
      if (bytes_sent >= 130 && bytes_sent < 220) begin
        quiet = 1'b1;
      end else begin
        quiet = 1'b0;
      end
      if (bytes_sent >= 240 && bytes_sent < 260) begin
        release_input();
        wait_drained();
      end
    end

    release_input();
    wait_drained();
    repeat (20) @(posedge clk);
    if (book.errors == 0) begin
      $display("PASS base64url_encoder");
    end else begin
      $display("FAIL base64url_encoder");
    end
    $finish;
  end
endmodule

// ----- files.f -----
sv/b64u_pkg.sv
sv/b64u_front.sv
sv/b64u_queue.sv
sv/b64u_back.sv
sv/base64url_encoder.sv
sv/b64u_checker.sv
tb/sv/base64url_encoder_test.sv
